>>> hw/rtl/ica_pkg.sv
// Shared types and constants of the integer calculator ALU.
`default_nettype none

package ica_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int OPCODE_W       = 4;
    localparam int KIND_W         = 3;
    localparam int MUL_DIGIT      = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MOD  = 4'd4,
        OP_POW  = 4'd5,
        OP_FACT = 4'd6,
        OP_FIB  = 4'd7,
        OP_SQRT = 4'd8
    } opcode_t;

    // Work class decided by the front end.
    typedef enum logic [KIND_W-1:0] {
        K_IMM  = 3'd0,
        K_MUL  = 3'd1,
        K_DIV  = 3'd2,
        K_MOD  = 3'd3,
        K_POW  = 3'd4,
        K_FACT = 3'd5,
        K_FIB  = 3'd6,
        K_SQRT = 3'd7
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_POW_A,
        ST_POW_S,
        ST_FACT,
        ST_FIB_C,
        ST_FIB_D0,
        ST_FIB_D1,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/integer_calculator_alu.sv
// Top level of the integer calculator ALU: front end, queue and execution unit.
`default_nettype none

// Channel   Direction  Beat contents
// s_*       in         tdata: opcode, operand_a, operand_b (low bits first)
// m_*       out        tdata: result
//
// The front end decodes a beat as it is accepted and writes it to a two-entry queue;
// add, sub, unknown opcodes and the exact special cases carry their answer with them.
// Each product comes from the shared multiplier; power and factorial use up to
// 2*DATA_WIDTH products and Fibonacci 3*DATA_WIDTH. A waiting result holds back only
// the next result; rst_n clears all control state at once.

module integer_calculator_alu #(
    parameter int DATA_WIDTH = ica_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // opcode [3:0], operand_a, operand_b, zero fill to whole bytes
    input  wire logic [((ica_pkg::OPCODE_W + 2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // result, zero fill to whole bytes
    output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int OW   = ica_pkg::OPCODE_W;
    localparam int KW   = ica_pkg::KIND_W;
    localparam int MW   = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int QW   = KW + 2 * DATA_WIDTH;

    logic                  q_full;
    logic                  q_empty;
    logic                  q_push;
    logic                  q_pop;
    logic [KW-1:0]         f_kind;
    logic [DATA_WIDTH-1:0] f_a;
    logic [DATA_WIDTH-1:0] f_b;
    logic [QW-1:0]         q_head;
    logic [DATA_WIDTH-1:0] result;

    ica_front #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_front (
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .opcode   (s_tdata[OW-1:0]),
        .operand_a(s_tdata[OW+DATA_WIDTH-1:OW]),
        .operand_b(s_tdata[OW+2*DATA_WIDTH-1:OW+DATA_WIDTH]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_kind   (f_kind),
        .q_a      (f_a),
        .q_b      (f_b)
    );

    ica_queue #(
        .WIDTH(QW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data({f_b, f_a, f_kind}),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    ica_back #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_kind   (q_head[KW-1:0]),
        .q_a      (q_head[KW+DATA_WIDTH-1:KW]),
        .q_b      (q_head[KW+2*DATA_WIDTH-1:KW+DATA_WIDTH]),
        .q_pop    (q_pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (result)
    );

    assign m_tdata = MW'(result);

endmodule

`default_nettype wire

>>> hw/rtl/ica_front.sv
// Front end: decodes each input beat and resolves the cases with a ready answer.
`default_nettype none

module ica_front #(
    parameter int DATA_WIDTH = ica_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [ica_pkg::OPCODE_W-1:0] opcode,
    input  wire logic [DATA_WIDTH-1:0]       operand_a,
    input  wire logic [DATA_WIDTH-1:0]       operand_b,
    input  wire logic                        q_full,
    output logic                             q_push,
    output logic [ica_pkg::KIND_W-1:0]       q_kind,
    output logic [DATA_WIDTH-1:0]            q_a,
    output logic [DATA_WIDTH-1:0]            q_b
);

    localparam logic [DATA_WIDTH-1:0] ONES  = {DATA_WIDTH{1'b1}};
    localparam logic [DATA_WIDTH-1:0] MAXV  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] ONE   = DATA_WIDTH'(1);
    localparam logic [DATA_WIDTH-1:0] FLIMIT = DATA_WIDTH'(2 * DATA_WIDTH);

    ica_pkg::kind_t kind;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign q_kind   = kind;

    always_comb
    begin
        kind = ica_pkg::K_IMM;
        q_a  = operand_a;
        q_b  = operand_b;
        unique case (ica_pkg::opcode_t'(opcode))
            ica_pkg::OP_ADD:
                q_a = operand_a + operand_b;
            ica_pkg::OP_SUB:
                q_a = operand_a - operand_b;
            ica_pkg::OP_MUL:
                kind = ica_pkg::K_MUL;
            ica_pkg::OP_DIV, ica_pkg::OP_MOD:
            begin
                if (operand_b == '0)
                    q_a = MAXV;
                else if (opcode == ica_pkg::OP_DIV)
                    kind = ica_pkg::K_DIV;
                else
                    kind = ica_pkg::K_MOD;
            end
            ica_pkg::OP_POW:
            begin
                // A negative exponent leaves only a few exact answers.
                if (operand_b[DATA_WIDTH-1])
                begin
                    if (operand_a == ONE)
                        q_a = ONE;
                    else if (operand_a == ONES)
                        q_a = operand_b[0] ? ONES : ONE;
                    else if (operand_a == '0)
                        q_a = MAXV;
                    else
                        q_a = '0;
                end
                else
                    kind = ica_pkg::K_POW;
            end
            ica_pkg::OP_FACT:
            begin
                // Past this point the product holds enough factors of two to vanish.
                if (operand_a >= FLIMIT)
                    q_a = '0;
                else
                    kind = ica_pkg::K_FACT;
            end
            ica_pkg::OP_FIB:
                kind = ica_pkg::K_FIB;
            ica_pkg::OP_SQRT:
                kind = ica_pkg::K_SQRT;
            default:
                q_a = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/ica_queue.sv
// Two-entry queue between the front end and the execution unit.
`default_nettype none

module ica_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head,
    output logic                  full,
    output logic                  empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ica_mul.sv
// Multi-cycle multiplier giving the low word of a product, one digit of b per cycle.
`default_nettype none

module ica_mul #(
    parameter int DATA_WIDTH = ica_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DATA_WIDTH-1:0] a,
    input  wire logic [DATA_WIDTH-1:0] b,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      product
);

    localparam int D    = ica_pkg::MUL_DIGIT;
    localparam int CH   = (DATA_WIDTH + D - 1) / D;
    localparam int BW   = CH * D;
    localparam int CNTW = $clog2(CH + 1);

    logic [DATA_WIDTH-1:0]   a_reg;
    logic [BW-1:0]           b_reg;
    logic [DATA_WIDTH-1:0]   acc_reg;
    logic [CNTW-1:0]         cnt_reg;
    logic                    done_reg;
    logic [DATA_WIDTH+D-1:0] pp;

    assign pp      = a_reg * b_reg[D-1:0];
    assign done    = done_reg;
    assign product = acc_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= BW'(b);
            acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= acc_reg + pp[DATA_WIDTH-1:0];
            a_reg   <= a_reg << D;
            b_reg   <= b_reg >> D;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && (cnt_reg == CNTW'(1));
            if (start)
                cnt_reg <= CNTW'(CH);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNTW'(1);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ica_back.sv
// Execution unit: sequencer for the iterative operations and the result register.
`default_nettype none

module ica_back #(
    parameter int DATA_WIDTH = ica_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_empty,
    input  wire logic [ica_pkg::KIND_W-1:0]  q_kind,
    input  wire logic [DATA_WIDTH-1:0]       q_a,
    input  wire logic [DATA_WIDTH-1:0]       q_b,
    output logic                             q_pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [DATA_WIDTH-1:0]            out_data
);

    localparam int W      = DATA_WIDTH;
    localparam int CW     = $clog2(W + 1);
    localparam int SQ_TOP = ((W - 1) / 2) * 2;

    ica_pkg::state_t state_reg, state_next;

    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W-1:0]  z_reg, z_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  w_reg, w_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_q_reg, neg_q_next;
    logic          neg_r_reg, neg_r_next;
    logic          rem_reg, rem_next;
    logic          issued_reg, issued_next;
    logic          out_valid_reg, out_valid_next;
    logic [W-1:0]  out_reg, out_next;

    logic          mul_start;
    logic [W-1:0]  mul_a;
    logic [W-1:0]  mul_b;
    logic          mul_done;
    logic [W-1:0]  mul_p;

    logic [W:0]    div_r2;
    logic [W:0]    div_diff;
    logic [W-1:0]  fib_t;
    logic [W-1:0]  fib_d;
    logic [W:0]    sq_sum;

    ica_mul #(
        .DATA_WIDTH(W)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .product(mul_p)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign div_r2   = {r_reg, x_reg[W-1]};
    assign div_diff = div_r2 - {1'b0, y_reg};
    assign fib_t    = (y_reg << 1) - x_reg;
    assign fib_d    = w_reg + mul_p;
    assign sq_sum   = {1'b0, x_reg} + {1'b0, y_reg};

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        r_reg     <= r_next;
        w_reg     <= w_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        rem_reg   <= rem_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ica_pkg::ST_IDLE;
            cnt_reg       <= '0;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        r_next         = r_reg;
        w_next         = w_reg;
        cnt_next       = cnt_reg;
        neg_q_next     = neg_q_reg;
        neg_r_next     = neg_r_reg;
        rem_next       = rem_reg;
        issued_next    = issued_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop          = 1'b0;
        mul_start      = 1'b0;
        mul_a          = x_reg;
        mul_b          = y_reg;

        // Multiply states issue once, then wait for the product.
        unique case (state_reg)
            ica_pkg::ST_POW_S, ica_pkg::ST_FIB_D1:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            ica_pkg::ST_FACT:
                mul_b = z_reg;
            ica_pkg::ST_FIB_C:
                mul_b = fib_t;
            ica_pkg::ST_FIB_D0:
                mul_b = x_reg;
            default:
                mul_b = y_reg;
        endcase

        unique case (state_reg)
            ica_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (ica_pkg::kind_t'(q_kind))
                        ica_pkg::K_IMM:
                        begin
                            x_next     = q_a;
                            state_next = ica_pkg::ST_DONE;
                        end
                        ica_pkg::K_MUL:
                        begin
                            x_next     = q_a;
                            y_next     = q_b;
                            state_next = ica_pkg::ST_MUL;
                        end
                        ica_pkg::K_DIV, ica_pkg::K_MOD:
                        begin
                            x_next     = q_a[W-1] ? ('0 - q_a) : q_a;
                            y_next     = q_b[W-1] ? ('0 - q_b) : q_b;
                            r_next     = '0;
                            cnt_next   = CW'(W);
                            neg_q_next = q_a[W-1] ^ q_b[W-1];
                            neg_r_next = q_a[W-1];
                            rem_next   = (q_kind == ica_pkg::K_MOD);
                            state_next = ica_pkg::ST_DIV;
                        end
                        ica_pkg::K_POW:
                        begin
                            x_next     = W'(1);
                            y_next     = q_a;
                            z_next     = q_b;
                            state_next = ica_pkg::ST_POW_A;
                        end
                        ica_pkg::K_FACT:
                        begin
                            x_next     = W'(1);
                            y_next     = q_a;
                            z_next     = W'(2);
                            state_next = ica_pkg::ST_FACT;
                        end
                        ica_pkg::K_FIB:
                        begin
                            x_next     = '0;
                            y_next     = W'(1);
                            z_next     = q_a;
                            cnt_next   = CW'(W);
                            state_next = ica_pkg::ST_FIB_C;
                        end
                        ica_pkg::K_SQRT:
                        begin
                            x_next     = '0;
                            y_next     = W'(1) << SQ_TOP;
                            z_next     = q_a;
                            state_next = ica_pkg::ST_SQRT;
                        end
                        default:
                            state_next = ica_pkg::ST_IDLE;
                    endcase
                end
            end

            ica_pkg::ST_MUL:
            begin
                if (!issued_reg)
                begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next = 1'b0;
                    x_next      = mul_p;
                    state_next  = ica_pkg::ST_DONE;
                end
            end

            ica_pkg::ST_DIV:
            begin
                // Restoring division: one quotient bit per cycle.
                x_next = {x_reg[W-2:0], !div_diff[W]};
                r_next = div_diff[W] ? div_r2[W-1:0] : div_diff[W-1:0];
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    if (rem_reg)
                        x_next = neg_r_reg ? ('0 - r_next) : r_next;
                    else
                        x_next = neg_q_reg ? ('0 - x_next) : x_next;
                    state_next = ica_pkg::ST_DONE;
                end
            end

            ica_pkg::ST_POW_A:
            begin
                if (z_reg == '0)
                    state_next = ica_pkg::ST_DONE;
                else if (!z_reg[0])
                    state_next = ica_pkg::ST_POW_S;
                else if (!issued_reg)
                begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next = 1'b0;
                    x_next      = mul_p;
                    state_next  = ica_pkg::ST_POW_S;
                end
            end

            ica_pkg::ST_POW_S:
            begin
                if (!issued_reg)
                begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next = 1'b0;
                    y_next      = mul_p;
                    z_next      = z_reg >> 1;
                    state_next  = ica_pkg::ST_POW_A;
                end
            end

            ica_pkg::ST_FACT:
            begin
                if (z_reg > y_reg)
                    state_next = ica_pkg::ST_DONE;
                else if (!issued_reg)
                begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next = 1'b0;
                    x_next      = mul_p;
                    z_next      = z_reg + W'(1);
                end
            end

            ica_pkg::ST_FIB_C:
            begin
                if (!issued_reg)
                begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next = 1'b0;
                    r_next      = mul_p;
                    state_next  = ica_pkg::ST_FIB_D0;
                end
            end

            ica_pkg::ST_FIB_D0:
            begin
                if (!issued_reg)
                begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next = 1'b0;
                    w_next      = mul_p;
                    state_next  = ica_pkg::ST_FIB_D1;
                end
            end

            ica_pkg::ST_FIB_D1:
            begin
                if (!issued_reg)
                begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next = 1'b0;
                    // Fast doubling: step to F(2k) or F(2k+1) by the next index bit.
                    if (z_reg[W-1])
                    begin
                        x_next = fib_d;
                        y_next = r_reg + fib_d;
                    end
                    else
                    begin
                        x_next = r_reg;
                        y_next = fib_d;
                    end
                    z_next   = z_reg << 1;
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                        state_next = ica_pkg::ST_DONE;
                    else
                        state_next = ica_pkg::ST_FIB_C;
                end
            end

            ica_pkg::ST_SQRT:
            begin
                if (y_reg == '0)
                    state_next = ica_pkg::ST_DONE;
                else
                begin
                    if ({1'b0, z_reg} >= sq_sum)
                    begin
                        z_next = z_reg - sq_sum[W-1:0];
                        x_next = (x_reg >> 1) + y_reg;
                    end
                    else
                        x_next = x_reg >> 1;
                    y_next = y_reg >> 2;
                end
            end

            ica_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = x_reg;
                    out_valid_next = 1'b1;
                    state_next     = ica_pkg::ST_IDLE;
                end
            end

            default:
                state_next = ica_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> bench/ica_checker.sv
// Checker for the integer calculator ALU: predicts each result and compares it.
`timescale 1ns / 100ps

module ica_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    output int               mismatches,
    output int               pending
);

    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    logic [31:0] expected_results[$];

    function automatic logic [31:0] signed_divide(logic [31:0] a, logic [31:0] b,
                                                  bit want_rem);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] r;
        if (b == 0)
            return INT_MAX;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        r = ma % mb;
        if (a[31] != b[31])
            q = -q;
        if (a[31])
            r = -r;
        return want_rem ? r : q;
    endfunction

    function automatic logic [31:0] power_of(logic [31:0] base, logic [31:0] e);
        logic [31:0] acc;
        logic [31:0] sq;
        acc = 1;
        sq = base;
        if (e[31])
        begin
            if (base == 32'd1)
                return 1;
            if (base == 32'hFFFF_FFFF)
                return e[0] ? 32'hFFFF_FFFF : 32'd1;
            if (base == 0)
                return INT_MAX;
            return 0;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (e[i])
                acc = acc * sq;
            sq = sq * sq;
        end
        return acc;
    endfunction

    function automatic logic [31:0] factorial_of(logic [31:0] n);
        logic [31:0] acc;
        acc = 1;
        if (n >= 64)
            return 0;
        for (int k = 2; k <= n; k++)
            acc = acc * k;
        return acc;
    endfunction

    function automatic logic [31:0] fibonacci_of(logic [31:0] n);
        logic [31:0] f0;
        logic [31:0] f1;
        logic [31:0] c;
        logic [31:0] d;
        f0 = 0;
        f1 = 1;
        for (int i = 31; i >= 0; i--)
        begin
            c = f0 * (2 * f1 - f0);
            d = f0 * f0 + f1 * f1;
            if (n[i])
            begin
                f0 = d;
                f1 = c + d;
            end
            else
            begin
                f0 = c;
                f1 = d;
            end
        end
        return f0;
    endfunction

    // Builds the root one bit at a time from the top, keeping a bit while the
    // square stays within the operand.
    function automatic logic [31:0] isqrt_of(logic [31:0] x);
        logic [31:0] root;
        root = '0;
        for (int i = 15; i >= 0; i--)
        begin
            root[i] = 1'b1;
            if (64'(root) * 64'(root) > 64'(x))
                root[i] = 1'b0;
        end
        return root;
    endfunction

    function automatic logic [31:0] alu_result(logic [3:0] op, logic [31:0] a,
                                               logic [31:0] b);
        case (op)
            ica_pkg::OP_ADD:  return a + b;
            ica_pkg::OP_SUB:  return a - b;
            ica_pkg::OP_MUL:  return a * b;
            ica_pkg::OP_DIV:  return signed_divide(a, b, 1'b0);
            ica_pkg::OP_MOD:  return signed_divide(a, b, 1'b1);
            ica_pkg::OP_POW:  return power_of(a, b);
            ica_pkg::OP_FACT: return factorial_of(a);
            ica_pkg::OP_FIB:  return fibonacci_of(a);
            ica_pkg::OP_SQRT: return isqrt_of(a);
            default: return 0;
        endcase
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(alu_result(s_tdata[3:0], s_tdata[35:4],
                                                      s_tdata[67:36]));
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want !== m_tdata)
                    begin
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $time, want, m_tdata);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

>>> bench/tb_integer_calculator_alu.sv
// Testbench top for the integer calculator ALU: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_integer_calculator_alu;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          mismatches;
    int          pending;
    // While set, neither side idles; this gives a stretch at full rate.
    bit          steady;

    integer_calculator_alu DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    ica_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .mismatches(mismatches),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // The result side stalls at random, with a chance of about 32 in a hundred.
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= 32);

    // Sends one beat; the sender may first idle for a random number of cycles.
    task automatic send_beat(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        while (!steady && $urandom_range(99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, b, a, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Random operand with a bias toward the edges and small magnitudes.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5))
            0: return $urandom_range(20);
            1: return -$urandom_range(20);
            2: return 32'h8000_0000 ^ $urandom_range(3);
            3: return 32'h7FFF_FFFF - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [3:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        steady   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: wraps, division corners, power corners, unary edges.
        send_beat(ica_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1);
        send_beat(ica_pkg::OP_SUB, 32'h8000_0000, 32'd1);
        send_beat(ica_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(ica_pkg::OP_DIV, -32'd7, 32'd2);
        send_beat(ica_pkg::OP_MOD, -32'd7, 32'd2);
        send_beat(ica_pkg::OP_DIV, 32'd5, 32'd0);
        send_beat(ica_pkg::OP_MOD, 32'd5, 32'd0);
        send_beat(ica_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_beat(ica_pkg::OP_MOD, 32'h8000_0000, 32'hFFFF_FFFF);
        send_beat(ica_pkg::OP_POW, 32'd0, 32'd0);
        send_beat(ica_pkg::OP_POW, 32'd3, 32'd40);
        send_beat(ica_pkg::OP_POW, 32'd1, 32'hFFFF_FFFF);
        send_beat(ica_pkg::OP_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_beat(ica_pkg::OP_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(ica_pkg::OP_POW, 32'd0, 32'h8000_0000);
        send_beat(ica_pkg::OP_POW, 32'd2, 32'hFFFF_FFFF);
        send_beat(ica_pkg::OP_FACT, 32'd0, 32'hFFFF_FFFF);
        send_beat(ica_pkg::OP_FACT, 32'd33, 32'd0);
        send_beat(ica_pkg::OP_FACT, 32'hFFFF_FFFF, 32'd0);
        send_beat(ica_pkg::OP_FIB, 32'd0, 32'd0);
        send_beat(ica_pkg::OP_FIB, 32'd1, 32'd0);
        send_beat(ica_pkg::OP_FIB, 32'hFFFF_FFFF, 32'd0);
        send_beat(ica_pkg::OP_SQRT, 32'hFFFF_FFFF, 32'd0);
        send_beat(ica_pkg::OP_SQRT, 32'd0, 32'd0);
        send_beat(4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random part; a stretch in the middle runs without idling.
        for (int n = 0; n < 900; n++)
        begin
            steady = (n >= 400 && n < 500);
            op = 4'($urandom_range(15));
            if ($urandom_range(3) != 0)
                op = 4'($urandom_range(8));
            a = pick_operand();
            b = pick_operand();
            send_beat(op, a, b);
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        // One more edge so that the checker has logged the last accepted beat.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog in case the run never finishes: it reports mismatches and stops.
    initial
    begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
